// File: rtl/tclt_pkg.sv
// Package: types, constants and codes of the client lease table.
`timescale 1ns / 1ps
package tclt_pkg;
	localparam int CLIENTS = 128;
	localparam int IDX_W = $clog2(CLIENTS);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [15:0] VIRT_HI = 16'hA9FE;
	localparam logic [15:0] LOW_RESET = 16'h0001;

	localparam logic [1:0] ST_UNUSED = 2'd0;
	localparam logic [1:0] ST_ACTIVE = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CLIENT = 2'd1;
	localparam logic [1:0] OP_OUT = 2'd2;

	localparam logic [1:0] ACT_REPLY = 2'd0;
	localparam logic [1:0] ACT_FWD = 2'd1;
	localparam logic [1:0] ACT_TUNNEL = 2'd2;
	localparam logic [1:0] ACT_DROP = 2'd3;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_UNKNOWN = 2'd2;
	localparam logic [1:0] STS_NOTFOUND = 2'd3;

	localparam logic [2:0] REG_LEASE = 3'd0;
	localparam logic [2:0] REG_IPREQ = 3'd1;
	localparam logic [2:0] REG_DATA = 3'd2;
	localparam logic [2:0] REG_KAREQ = 3'd3;
	localparam logic [2:0] REG_KAREP = 3'd4;
	localparam logic [2:0] REG_INVAL = 3'd5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  msg_type;
		logic [31:0] lookup_addr;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  reply_type;
		logic [31:0] addr_out;
		logic [1:0]  status;
	} out_word_t;

	typedef struct packed {
		logic [15:0] lease_seconds;
		logic [7:0]  code_ip_request;
		logic [7:0]  code_tunnel_data;
		logic [7:0]  code_keepalive_request;
		logic [7:0]  code_keepalive_reply;
		logic [7:0]  code_ip_invalid;
	} cfg_t;

	// one entry as held in the table memory
	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] pub;
		logic [31:0] virt;
		logic [31:0] seen;
	} entry_t;
endpackage

// File: rtl/tclt_cfg.sv
// APB register file of the lease table.
`timescale 1ns / 1ps
module tclt_cfg import tclt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t cfg_q;
	logic [2:0] ridx;

	assign ridx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd60, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5};
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_LEASE: cfg_q.lease_seconds <= pwdata[15:0];
				REG_IPREQ: cfg_q.code_ip_request <= pwdata[7:0];
				REG_DATA:  cfg_q.code_tunnel_data <= pwdata[7:0];
				REG_KAREQ: cfg_q.code_keepalive_request <= pwdata[7:0];
				REG_KAREP: cfg_q.code_keepalive_reply <= pwdata[7:0];
				REG_INVAL: cfg_q.code_ip_invalid <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (ridx)
			REG_LEASE: prdata = {16'd0, cfg_q.lease_seconds};
			REG_IPREQ: prdata = {24'd0, cfg_q.code_ip_request};
			REG_DATA:  prdata = {24'd0, cfg_q.code_tunnel_data};
			REG_KAREQ: prdata = {24'd0, cfg_q.code_keepalive_request};
			REG_KAREP: prdata = {24'd0, cfg_q.code_keepalive_reply};
			REG_INVAL: prdata = {24'd0, cfg_q.code_ip_invalid};
			default:   prdata = 32'd0;
		endcase
	end
endmodule

// File: rtl/tclt_core.sv
// Sequencer: entry memory, free stack, scans, sweep and replies.
`timescale 1ns / 1ps
module tclt_core import tclt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	// entry memory with valid bits for the state field
	entry_t mem [CLIENTS];
	logic [CLIENTS-1:0] vld_q;
	logic [IDX_W-1:0] stk [CLIENTS];

	logic [2:0] state_q;
	in_word_t req_q;
	logic [CNT_W-1:0] ptr_q;       // scan address issued
	logic rd_v_s1;
	logic [IDX_W-1:0] rd_a_s1;
	entry_t rd_s1;
	logic rd_ok_s1;
	logic [IDX_W-1:0] stk_rd_s1;
	logic [CNT_W-1:0] free_q;
	logic [15:0] low_q;
	logic [31:0] now_q, sweep_q;
	logic hit_q, unused_q;
	logic [IDX_W-1:0] hit_idx_q, unused_idx_q;
	entry_t wr_q;
	logic [IDX_W-1:0] wr_a_q;
	out_word_t res_q;
	logic res_v_q, out_v_q;
	out_word_t out_q;

	logic mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t mem_wd;
	logic stk_we;
	logic [IDX_W-1:0] stk_wa;
	logic [IDX_W-1:0] rd_addr;
	logic [1:0] rd_st;
	logic match;
	logic accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || res_v_q;
	assign out_valid = out_v_q;
	assign out_data = out_q;
	// a pop reads the entry named by the stack top, scans walk ptr_q
	assign rd_addr = (state_q == S_POP) ? stk_rd_s1 : ptr_q[IDX_W-1:0];
	assign rd_st = rd_ok_s1 ? rd_s1.st : ST_UNUSED;

	// match of the read entry against the request
	always_comb begin
		if (req_q.operation == OP_OUT)
			match = (rd_st == ST_ACTIVE) && (rd_s1.virt == req_q.lookup_addr);
		else
			match = (rd_st == ST_ACTIVE) && (rd_s1.pub == req_q.lookup_addr);
	end

	// memories: one write and one read port each, read registered
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[rd_addr];
		if (stk_we) stk[stk_wa] <= rd_a_s1;
		stk_rd_s1 <= stk[free_q[IDX_W-1:0] - 1'b1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_ok_s1 <= 1'b0;
		else rd_ok_s1 <= vld_q[rd_addr];
	end

	// write port select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_a_s1;
		mem_wd = rd_s1;
		stk_we = 1'b0;
		stk_wa = free_q[IDX_W-1:0];
		if (state_q == S_SWEEP && rd_v_s1 && rd_st == ST_ACTIVE &&
		    (now_q - rd_s1.seen) > {16'd0, cfg.lease_seconds}) begin
			mem_we = 1'b1;
			mem_wd.st = ST_FREE;
			stk_we = 1'b1;
		end else if (state_q == S_WRITE) begin
			mem_we = 1'b1;
			mem_wa = wr_a_q;
			mem_wd = wr_q;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			free_q <= '0;
			low_q <= LOW_RESET;
			now_q <= '0;
			sweep_q <= '0;
			ptr_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_a_s1 <= '0;
			res_v_q <= 1'b0;
			out_v_q <= 1'b0;
			hit_q <= 1'b0;
			unused_q <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (res_v_q && (!out_v_q || !out_stall)) begin
				out_q <= res_q;
				out_v_q <= 1'b1;
				res_v_q <= 1'b0;
			end
			rd_v_s1 <= 1'b0;
			rd_a_s1 <= rd_addr;
			if (mem_we) vld_q[mem_wa] <= 1'b1;
			if (stk_we) free_q <= free_q + 1'b1;
			unique case (state_q)
				S_IDLE: begin
					// ptr_q low bits are zero here, so entry 0 is read on acceptance
					if (accept) begin
						req_q <= in_data;
						hit_q <= 1'b0;
						unused_q <= 1'b0;
						if (in_data.operation == OP_TICK) begin
							now_q <= now_q + 1'b1;
						end else if (in_data.operation == OP_OUT) begin
							state_q <= S_SCAN;
							rd_v_s1 <= 1'b1;
							ptr_q <= CNT_W'(1);
						end else if (in_data.operation == OP_CLIENT) begin
							rd_v_s1 <= 1'b1;
							ptr_q <= CNT_W'(1);
							if ((now_q - sweep_q) > {16'd0, cfg.lease_seconds}) begin
								state_q <= S_SWEEP;
								sweep_q <= now_q;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SWEEP: begin
					// releases are pushed as the read data comes back
					if (ptr_q == CNT_W'(CLIENTS)) begin
						if (!rd_v_s1) begin
							state_q <= S_SCAN;
							ptr_q <= CNT_W'(1);
							rd_v_s1 <= 1'b1;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end
				end
				S_SCAN: begin
					if (rd_v_s1) begin
						if (match && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= rd_a_s1;
							wr_q <= rd_s1;
						end
						if (rd_st == ST_UNUSED && !unused_q) begin
							unused_q <= 1'b1;
							unused_idx_q <= rd_a_s1;
						end
					end
					if (ptr_q != CNT_W'(CLIENTS)) begin
						ptr_q <= ptr_q + 1'b1;
						rd_v_s1 <= 1'b1;
					end else if (!rd_v_s1) begin
						state_q <= S_RESP;
					end
				end
				S_POP: begin
					// the entry under the stack top is read first, then taken once its data is back
					if (!rd_v_s1) begin
						ptr_q <= '0;
						rd_v_s1 <= 1'b1;
					end else begin
						wr_q <= '{ST_ACTIVE, req_q.lookup_addr, rd_s1.virt, now_q};
						wr_a_q <= rd_a_s1;
						free_q <= free_q - 1'b1;
						res_q <= '{ACT_REPLY, cfg.code_tunnel_data, rd_s1.virt, STS_OK};
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					res_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RESP: begin
					state_q <= S_IDLE;
					res_v_q <= 1'b1;
					if (req_q.operation == OP_OUT) begin
						res_q <= hit_q
						    ? out_word_t'{ACT_TUNNEL, cfg.code_tunnel_data, wr_q.pub, STS_OK}
						    : out_word_t'{ACT_DROP, 8'd0, 32'd0, STS_NOTFOUND};
					end else if (req_q.msg_type == cfg.code_ip_request) begin
						if (hit_q) begin
							res_q <= '{ACT_REPLY, cfg.code_tunnel_data, wr_q.virt, STS_OK};
						end else if (free_q != '0) begin
							res_v_q <= 1'b0;
							state_q <= S_POP;
						end else if (unused_q) begin
							res_v_q <= 1'b0;
							state_q <= S_WRITE;
							wr_a_q <= unused_idx_q;
							wr_q <= '{ST_ACTIVE, req_q.lookup_addr, {VIRT_HI, low_q}, now_q};
							low_q <= low_q + 1'b1;
							res_q <= '{ACT_REPLY, cfg.code_tunnel_data, {VIRT_HI, low_q},
							           STS_OK};
						end else begin
							res_q <= '{ACT_DROP, 8'd0, 32'd0, STS_FULL};
						end
					end else if (req_q.msg_type == cfg.code_tunnel_data ||
					             req_q.msg_type == cfg.code_keepalive_request) begin
						if (hit_q) begin
							res_v_q <= 1'b0;
							state_q <= S_WRITE;
							wr_a_q <= hit_idx_q;
							wr_q.seen <= now_q;
							res_q <= (req_q.msg_type == cfg.code_tunnel_data)
							    ? out_word_t'{ACT_FWD, 8'd0, 32'd0, STS_OK}
							    : out_word_t'{ACT_REPLY, cfg.code_keepalive_reply, 32'd0,
							                  STS_OK};
						end else begin
							res_q <= '{ACT_REPLY, cfg.code_ip_invalid, 32'd0, STS_NOTFOUND};
						end
					end else begin
						res_q <= '{ACT_DROP, 8'd0, 32'd0, STS_UNKNOWN};
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/tunnel_client_lease_table_unit.sv
// Top level of the tunnel client lease table.
// A tick word advances the time count and gives no output. A client or outbound
// word is answered after a linear scan of the entry memory (one read a cycle),
// then a write-back when an entry changes, after a pop of a released entry.
// A client word may start a sweep before its scan. One input word at a time.
// Reset clears control state and entry valid bits and loads the register defaults.
`timescale 1ns / 1ps
module tunnel_client_lease_table_unit import tclt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t cfg;

	tclt_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	tclt_core u_core (.clk, .arst_n, .cfg, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data);
endmodule

// File: rtl/tclt_checker.sv
// Port checker for the lease table, bound to the top level.
`timescale 1ns / 1ps
module tclt_checker import tclt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data,
	input logic      pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word changed under stall");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STS_OK && out_data.action == ACT_REPLY &&
		out_data.addr_out != 32'd0 |-> out_data.addr_out[31:16] == VIRT_HI)
		else $error("grant outside link-local range");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_DROP |->
		out_data.reply_type == 8'd0 && out_data.addr_out == 32'd0)
		else $error("dropped word carries a type or an address");
endmodule

bind tunnel_client_lease_table_unit tclt_checker u_chk (.clk, .arst_n, .out_valid,
	.out_stall, .out_data, .pready);
